FILE: sv/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared constants and types for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

  // Width of the operand and result ports.
  localparam int unsigned PORT_WIDTH = 64;

  // Default width of the arithmetic.
  localparam int unsigned DATA_WIDTH_DEFAULT = 64;

  // Control bits that travel alongside each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic dbz;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: sv/udiv_step.sv
// ----------------------------------------------------------------------------
// udiv_step
// One registered restoring-division step: produces one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_step #(
  parameter int unsigned W = udiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  udiv_pkg::ctrl_t in_ctrl,
  input  logic [W-1:0]   in_rem,
  input  logic [W-1:0]   in_num,
  input  logic [W-1:0]   in_den,
  output udiv_pkg::ctrl_t out_ctrl,
  output logic [W-1:0]   out_rem,
  output logic [W-1:0]   out_num,
  output logic [W-1:0]   out_den
);

  import udiv_pkg::*;

  logic         carry;
  logic [W-1:0] shifted;
  logic [W+1:0] diff;
  logic         take;

  // The bit shifted out of the partial remainder makes it at least the
  // divisor on its own, so the comparison is done one bit wider.
  assign carry   = in_rem[W-1];
  assign shifted = {in_rem[W-2:0], in_num[W-1]};
  assign diff    = {1'b0, carry, shifted} - {2'b00, in_den};
  assign take    = ~diff[W+1];

  // The dividend register empties from the top while quotient bits fill it
  // from the bottom.
  always_ff @(posedge clk) begin
    out_ctrl.dbz <= in_ctrl.dbz;
    out_rem      <= take ? diff[W-1:0] : shifted;
    out_num      <= {in_num[W-2:0], take};
    out_den      <= in_den;
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else begin
      out_ctrl.valid <= in_ctrl.valid;
    end
  end

endmodule

`default_nettype wire

FILE: sv/unsigned_divider_64.sv
// ----------------------------------------------------------------------------
// unsigned_divider_64
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   -------   --------------   ---------------------------------------------
//   operands  start / busy     dividend[63:0], divisor[63:0]
//   results   done (strobe)    quotient[63:0], remainder[63:0], divide_by_zero
//
// An operand transfer takes place on each rising edge with start high and
// busy low. busy is never raised, so a new pair may enter on every cycle.
// Each result passes through DATA_WIDTH step stages, one per quotient bit,
// each holding a subtract and compare one bit wider than DATA_WIDTH,
// and then through the output register.
// The synchronous reset clears the valid bits of every stage; data
// registers are not reset. The receiver cannot stall, so results leave
// in order as one-cycle done strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_divider_64 #(
  parameter int unsigned DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [udiv_pkg::PORT_WIDTH-1:0] dividend,
  input  logic [udiv_pkg::PORT_WIDTH-1:0] divisor,
  output logic                            done,
  output logic [udiv_pkg::PORT_WIDTH-1:0] quotient,
  output logic [udiv_pkg::PORT_WIDTH-1:0] remainder,
  output logic                            divide_by_zero
);

  import udiv_pkg::*;

  // Total latency from operand transfer to the done strobe.
  localparam int unsigned LATENCY = DATA_WIDTH + 1;

  // Pipeline boundaries: index 0 is the operand ports, index DATA_WIDTH is
  // the output of the last step stage.
  ctrl_t                 ctrl_pipe [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_pipe  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] num_pipe  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_pipe  [0:DATA_WIDTH];

  logic [DATA_WIDTH-1:0] divisor_w;

  // The pipeline never refuses an operand pair.
  assign busy = 1'b0;

  // Only the low DATA_WIDTH bits of each operand take part.
  assign divisor_w       = divisor[DATA_WIDTH-1:0];
  assign ctrl_pipe[0].valid = start && !busy;
  assign ctrl_pipe[0].dbz   = (divisor_w == '0);
  assign rem_pipe[0]     = '0;
  assign num_pipe[0]     = dividend[DATA_WIDTH-1:0];
  assign den_pipe[0]     = divisor_w;

  // Stage k settles quotient bit DATA_WIDTH-1-k.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    udiv_step #(
      .W (DATA_WIDTH)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_ctrl  (ctrl_pipe[k]),
      .in_rem   (rem_pipe[k]),
      .in_num   (num_pipe[k]),
      .in_den   (den_pipe[k]),
      .out_ctrl (ctrl_pipe[k+1]),
      .out_rem  (rem_pipe[k+1]),
      .out_num  (num_pipe[k+1]),
      .out_den  (den_pipe[k+1])
    );
  end

  // Output register. A zero divisor forces both results to zero, and the
  // results are zero-extended to the port width.
  always_ff @(posedge clk) begin
    divide_by_zero <= ctrl_pipe[DATA_WIDTH].dbz;
    if (ctrl_pipe[DATA_WIDTH].dbz) begin
      quotient  <= '0;
      remainder <= '0;
    end else begin
      quotient  <= PORT_WIDTH'(num_pipe[DATA_WIDTH]);
      remainder <= PORT_WIDTH'(rem_pipe[DATA_WIDTH]);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_pipe[DATA_WIDTH].valid;
    end
  end

  // Every strobe comes from an operand transfer that has passed through all step stages and the output register.
  a_done_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching operand transfer");

  // The divide-by-zero flag follows the divisor that entered with the item.
  a_dbz_match : assert property (@(posedge clk) disable iff (rst)
    done |-> (divide_by_zero == ($past(divisor_w, LATENCY) == '0)))
    else $error("divide-by-zero flag does not match the divisor");

  // A proper division leaves a remainder below the divisor.
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    (done && !divide_by_zero) |->
      (remainder < PORT_WIDTH'($past(divisor_w, LATENCY))))
    else $error("remainder not below divisor");

  // Results never carry bits above the arithmetic width.
  a_upper_zero : assert property (@(posedge clk) disable iff (rst)
    done |-> ((quotient >> DATA_WIDTH) == '0) && ((remainder >> DATA_WIDTH) == '0))
    else $error("result bits set above the data width");

endmodule

`default_nettype wire
